// File: rtl/gsa_pkg.sv
// ---------------------------------------------------------------------------
// gsa_pkg: shared types and constants of the generational slot allocator
// Command and status codes, register indexes, controller/datapath
// handshake structs, FSM state type and the generation LFSR step.
// ---------------------------------------------------------------------------
package gsa_pkg;

   localparam int CMD_W     = 3;
   localparam int IDX_W     = 10;
   localparam int GEN_W     = 32;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 32;
   localparam int ALLOWED_W = 5;

   // commands
   localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FREE    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

   // result status
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_STALE    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_DISABLED = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SEED    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALLOWED = 1'd1;

   localparam logic [ALLOWED_W-1:0] ALLOWED_RESET = 5'd16;
   localparam logic [GEN_W-1:0]     SEED_RESET    = 32'd1;

   // x^32 + x^22 + x^2 + x + 1, Galois form, right shift
   localparam logic [GEN_W-1:0] LFSR_TAPS = 32'h8020_0003;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EXPAND,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic capture;   // latch the request fields
      logic read;      // read link/generation memories
      logic expand;    // initialize one slot of the next block
      logic exec;      // finish the command and load the response
   } dp_cmd_type;

   typedef struct packed {
      logic cmd_known;
      logic need_expand;
      logic expand_last;
   } dp_status_type;

   function automatic logic [GEN_W-1:0] lfsr_step(input logic [GEN_W-1:0] v);
      logic [GEN_W-1:0] s;
      s = {1'b0, v[GEN_W-1:1]};
      if (v[0]) begin
         s = s ^ LFSR_TAPS;
      end
      return s;
   endfunction

endpackage

// File: rtl/gsa_ctrl.sv
// ---------------------------------------------------------------------------
// gsa_ctrl: command sequencer of the slot allocator
// Walks each transaction through lookup, optional block expansion and
// execution, and drives the datapath by command strobes.
// ---------------------------------------------------------------------------
module gsa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  gsa_pkg::dp_status_type dp_status,
   output gsa_pkg::dp_cmd_type    dp_cmd,
   output logic                   busy
);

   gsa_pkg::state_type state_ff;
   gsa_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gsa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         gsa_pkg::ST_IDLE: begin
            if (start) begin
               dp_cmd.capture = 1'b1;
               state_in       = gsa_pkg::ST_LOOKUP;
            end
         end
         gsa_pkg::ST_LOOKUP: begin
            if (!dp_status.cmd_known) begin
               state_in = gsa_pkg::ST_IDLE;
            end else if (dp_status.need_expand) begin
               state_in = gsa_pkg::ST_EXPAND;
            end else begin
               dp_cmd.read = 1'b1;
               state_in    = gsa_pkg::ST_EXEC;
            end
         end
         gsa_pkg::ST_EXPAND: begin
            dp_cmd.expand = 1'b1;
            // back to lookup so the fresh head gets read
            if (dp_status.expand_last) begin
               state_in = gsa_pkg::ST_LOOKUP;
            end
         end
         gsa_pkg::ST_EXEC: begin
            dp_cmd.exec = 1'b1;
            state_in    = gsa_pkg::ST_IDLE;
         end
         default: begin
            state_in = gsa_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != gsa_pkg::ST_IDLE);

endmodule

// File: rtl/gsa_datapath.sv
// ---------------------------------------------------------------------------
// gsa_datapath: free list, generation store and response registers
// Holds the link and generation memories, the free-list pointers, the
// block count, the generation LFSR and the registered response.
// ---------------------------------------------------------------------------
module gsa_datapath #(
   parameter int BLOCKS          = 16,
   parameter int SLOTS_PER_BLOCK = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [gsa_pkg::CMD_W-1:0]           req_command,
   input  logic [gsa_pkg::IDX_W-1:0]           req_slot_index,
   input  logic [gsa_pkg::IDX_W-1:0]           req_handle_index,
   input  logic [gsa_pkg::GEN_W-1:0]           req_handle_generation,
   input  logic                                csr_we,
   input  logic [gsa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gsa_pkg::CSR_DAT_W-1:0]       csr_data,
   input  gsa_pkg::dp_cmd_type                 dp_cmd,
   output gsa_pkg::dp_status_type              dp_status,
   output logic                                rsp_strobe,
   output logic [gsa_pkg::STATUS_W-1:0]        rsp_status,
   output logic [gsa_pkg::IDX_W-1:0]           rsp_result_index,
   output logic [gsa_pkg::GEN_W-1:0]           rsp_result_generation
);

   localparam int TOTAL  = BLOCKS * SLOTS_PER_BLOCK;
   localparam int SLOT_W = $clog2(TOTAL);
   localparam int LIM_W  = $clog2(TOTAL + 1);
   localparam int ECMP_W = (LIM_W > gsa_pkg::IDX_W) ? LIM_W : gsa_pkg::IDX_W;
   localparam int BE_W   = $clog2(BLOCKS + 1);
   localparam int BCMP_W = (BE_W > gsa_pkg::ALLOWED_W) ? BE_W : gsa_pkg::ALLOWED_W;
   localparam int J_W    = $clog2(SLOTS_PER_BLOCK);

   // memories
   logic [gsa_pkg::GEN_W-1:0] gen_mem  [TOTAL];
   logic [SLOT_W-1:0]         link_mem [TOTAL];

   // latched request
   logic [gsa_pkg::CMD_W-1:0] cmd_q_ff;
   logic [gsa_pkg::IDX_W-1:0] sidx_q_ff;
   logic [gsa_pkg::IDX_W-1:0] hidx_q_ff;
   logic [gsa_pkg::GEN_W-1:0] hgen_q_ff;

   // allocator state
   logic [gsa_pkg::ALLOWED_W-1:0] allowed_ff, allowed_in;
   logic [gsa_pkg::GEN_W-1:0]     lfsr_ff, lfsr_in;
   logic [BE_W-1:0]               blocks_ff, blocks_in;
   logic [LIM_W-1:0]              limit_ff, limit_in;   // blocks * SLOTS_PER_BLOCK
   logic [SLOT_W-1:0]             head_ff, head_in;
   logic [SLOT_W-1:0]             tail_ff, tail_in;
   logic                          empty_ff, empty_in;
   logic [J_W-1:0]                j_ff, j_in;

   // memory read data
   logic [gsa_pkg::GEN_W-1:0] gen_rd_ff;
   logic [SLOT_W-1:0]         link_rd_ff;

   // response
   logic                         rsp_strobe_ff;
   logic [gsa_pkg::STATUS_W-1:0] rsp_status_ff, res_status;
   logic [gsa_pkg::IDX_W-1:0]    rsp_index_ff, res_index;
   logic [gsa_pkg::GEN_W-1:0]    rsp_gen_ff, res_gen;

   // combinational helpers
   logic [ECMP_W-1:0]         sidx_w, hidx_w, head_w;
   logic [SLOT_W-1:0]         sidx_slot, hidx_slot, rd_addr, exp_addr;
   logic                      sidx_ok, hidx_ok, pool_full, cmd_known, expand_last;
   logic [BCMP_W-1:0]         allowed_w, block_cap;
   logic [gsa_pkg::GEN_W-1:0] lfsr_next, fresh_gen, gen_inc, gen_bump;
   logic                      mem_we;
   logic [SLOT_W-1:0]         mem_waddr, link_wdata;
   logic [gsa_pkg::GEN_W-1:0] gen_wdata;

   assign sidx_w    = ECMP_W'(sidx_q_ff);
   assign hidx_w    = ECMP_W'(hidx_q_ff);
   assign head_w    = ECMP_W'(head_ff);
   assign sidx_slot = sidx_w[SLOT_W-1:0];
   assign hidx_slot = hidx_w[SLOT_W-1:0];
   assign sidx_ok   = sidx_w < ECMP_W'(limit_ff);
   assign hidx_ok   = hidx_w < ECMP_W'(limit_ff);

   assign allowed_w = BCMP_W'(allowed_ff);
   assign block_cap = (allowed_w < BCMP_W'(BLOCKS)) ? allowed_w : BCMP_W'(BLOCKS);
   assign pool_full = BCMP_W'(blocks_ff) >= block_cap;

   assign lfsr_next = gsa_pkg::lfsr_step(lfsr_ff);
   assign fresh_gen = (lfsr_next == '0) ? gsa_pkg::GEN_W'(1) : lfsr_next;
   assign gen_inc   = gen_rd_ff + gsa_pkg::GEN_W'(1);
   assign gen_bump  = (gen_inc == '0) ? gsa_pkg::GEN_W'(1) : gen_inc;

   assign exp_addr    = limit_ff[SLOT_W-1:0] + SLOT_W'(j_ff);
   assign expand_last = (j_ff == J_W'(SLOTS_PER_BLOCK - 1));

   always_comb begin
      unique case (cmd_q_ff) inside
         gsa_pkg::CMD_ALLOC, gsa_pkg::CMD_FREE, gsa_pkg::CMD_LOOKUP,
         gsa_pkg::CMD_REVERSE, gsa_pkg::CMD_CLEAR: cmd_known = 1'b1;
         default:                                   cmd_known = 1'b0;
      endcase
   end

   assign dp_status.cmd_known   = cmd_known;
   assign dp_status.need_expand = (cmd_q_ff == gsa_pkg::CMD_ALLOC) && empty_ff && !pool_full;
   assign dp_status.expand_last = expand_last;

   always_comb begin
      case (cmd_q_ff)
         gsa_pkg::CMD_ALLOC:  rd_addr = head_ff;
         gsa_pkg::CMD_LOOKUP: rd_addr = hidx_slot;
         default:             rd_addr = sidx_slot;
      endcase
   end

   // single write port: block expansion or free write-back
   always_comb begin
      mem_we     = 1'b0;
      mem_waddr  = exp_addr;
      gen_wdata  = fresh_gen;
      link_wdata = exp_addr + SLOT_W'(1);
      if (dp_cmd.expand) begin
         mem_we = 1'b1;
      end else if (dp_cmd.exec && (cmd_q_ff == gsa_pkg::CMD_FREE) && sidx_ok) begin
         mem_we     = 1'b1;
         mem_waddr  = sidx_slot;
         gen_wdata  = gen_bump;
         link_wdata = empty_ff ? sidx_slot : head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         gen_mem[mem_waddr]  <= gen_wdata;
         link_mem[mem_waddr] <= link_wdata;
      end
      if (dp_cmd.read) begin
         gen_rd_ff  <= gen_mem[rd_addr];
         link_rd_ff <= link_mem[rd_addr];
      end
   end

   // next state and result
   always_comb begin
      allowed_in = allowed_ff;
      lfsr_in    = lfsr_ff;
      blocks_in  = blocks_ff;
      limit_in   = limit_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      empty_in   = empty_ff;
      j_in       = j_ff;
      res_status = gsa_pkg::STATUS_OK;
      res_index  = '0;
      res_gen    = '0;

      if (dp_cmd.expand) begin
         lfsr_in = lfsr_next;
         j_in    = expand_last ? '0 : j_ff + J_W'(1);
         if (expand_last) begin
            head_in   = limit_ff[SLOT_W-1:0];
            tail_in   = exp_addr;
            empty_in  = 1'b0;
            blocks_in = blocks_ff + BE_W'(1);
            limit_in  = limit_ff + LIM_W'(SLOTS_PER_BLOCK);
         end
      end

      if (dp_cmd.exec) begin
         case (cmd_q_ff)
            gsa_pkg::CMD_ALLOC: begin
               if (empty_ff) begin
                  res_status = gsa_pkg::STATUS_FULL;
               end else begin
                  res_index = head_w[gsa_pkg::IDX_W-1:0];
                  res_gen   = gen_rd_ff;
                  if (head_ff == tail_ff) begin
                     empty_in = 1'b1;
                  end else begin
                     head_in = link_rd_ff;
                  end
               end
            end
            gsa_pkg::CMD_FREE: begin
               res_index = sidx_q_ff;
               if (!sidx_ok) begin
                  res_status = gsa_pkg::STATUS_DISABLED;
               end else begin
                  res_gen  = gen_bump;
                  head_in  = sidx_slot;
                  empty_in = 1'b0;
                  if (empty_ff) begin
                     tail_in = sidx_slot;
                  end
               end
            end
            gsa_pkg::CMD_LOOKUP: begin
               res_index = hidx_q_ff;
               if (!hidx_ok) begin
                  res_status = gsa_pkg::STATUS_DISABLED;
               end else if (gen_rd_ff != hgen_q_ff) begin
                  res_status = gsa_pkg::STATUS_STALE;
               end else begin
                  res_gen = gen_rd_ff;
               end
            end
            gsa_pkg::CMD_REVERSE: begin
               res_index = sidx_q_ff;
               if (!sidx_ok) begin
                  res_status = gsa_pkg::STATUS_DISABLED;
               end else begin
                  res_gen = gen_rd_ff;
               end
            end
            gsa_pkg::CMD_CLEAR: begin
               blocks_in = '0;
               limit_in  = '0;
               head_in   = '0;
               tail_in   = '0;
               empty_in  = 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (csr_we) begin
         unique case (csr_index)
            gsa_pkg::CSR_SEED:    lfsr_in    = csr_data;
            gsa_pkg::CSR_ALLOWED: allowed_in = csr_data[gsa_pkg::ALLOWED_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         allowed_ff    <= gsa_pkg::ALLOWED_RESET;
         lfsr_ff       <= gsa_pkg::SEED_RESET;
         blocks_ff     <= '0;
         limit_ff      <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         empty_ff      <= 1'b1;
         j_ff          <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         allowed_ff    <= allowed_in;
         lfsr_ff       <= lfsr_in;
         blocks_ff     <= blocks_in;
         limit_ff      <= limit_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         empty_ff      <= empty_in;
         j_ff          <= j_in;
         rsp_strobe_ff <= dp_cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         cmd_q_ff  <= req_command;
         sidx_q_ff <= req_slot_index;
         hidx_q_ff <= req_handle_index;
         hgen_q_ff <= req_handle_generation;
      end
      if (dp_cmd.exec) begin
         rsp_status_ff <= res_status;
         rsp_index_ff  <= res_index;
         rsp_gen_ff    <= res_gen;
      end
   end

   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_result_index      = rsp_index_ff;
   assign rsp_result_generation = rsp_gen_ff;

endmodule

// File: rtl/generational_slot_allocator_unit.sv
// ---------------------------------------------------------------------------
// generational_slot_allocator_unit: generational handle slot allocator
// Hands out handles (slot index + nonzero generation) from a free list
// of slots that grows one block at a time.
// ---------------------------------------------------------------------------
// Usage:
//  - Command channel: a transaction is taken when start is high and busy
//    is low. req_command selects allocate, free, lookup, reverse lookup
//    or clear; codes 5..7 are dropped without a response.
//  - Response channel: rsp_strobe marks one cycle of rsp_status,
//    rsp_result_index and rsp_result_generation. The receiver cannot
//    stall; it must take the response in that cycle.
//  - CSR channel: csr_ready is always high; index 0 loads the generation
//    seed (and reseeds the LFSR), index 1 sets how many blocks may be
//    enabled. Write only while the unit is idle.
//  - Sequence: a command passes through accept, memory read and execute;
//    the strobe comes in the cycle busy drops, so the next command can
//    be taken at the edge that ends it. An allocate on an empty free
//    list, while another block may be enabled, first initializes that
//    block, one slot per cycle through the single memory write port.
//  - Reset (synchronous): no blocks enabled, free list empty, LFSR = 1.
//    The memories need no clearing; only data of enabled slots is ever used.
// ---------------------------------------------------------------------------
module generational_slot_allocator_unit #(
   parameter int BLOCKS          = 16,
   parameter int SLOTS_PER_BLOCK = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // command channel
   input  logic                                start,
   output logic                                busy,
   input  logic [gsa_pkg::CMD_W-1:0]           req_command,
   input  logic [gsa_pkg::IDX_W-1:0]           req_slot_index,
   input  logic [gsa_pkg::IDX_W-1:0]           req_handle_index,
   input  logic [gsa_pkg::GEN_W-1:0]           req_handle_generation,
   // response channel
   output logic                                rsp_strobe,
   output logic [gsa_pkg::STATUS_W-1:0]        rsp_status,
   output logic [gsa_pkg::IDX_W-1:0]           rsp_result_index,
   output logic [gsa_pkg::GEN_W-1:0]           rsp_result_generation,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gsa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gsa_pkg::CSR_DAT_W-1:0]       csr_data
);

   gsa_pkg::dp_cmd_type    dp_cmd;
   gsa_pkg::dp_status_type dp_status;

   // register writes are never held off
   assign csr_ready = 1'b1;

   gsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd),
      .busy      (busy)
   );

   gsa_datapath #(
      .BLOCKS          (BLOCKS),
      .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .req_command           (req_command),
      .req_slot_index        (req_slot_index),
      .req_handle_index      (req_handle_index),
      .req_handle_generation (req_handle_generation),
      .csr_we                (csr_valid && csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .dp_cmd                (dp_cmd),
      .dp_status             (dp_status),
      .rsp_strobe            (rsp_strobe),
      .rsp_status            (rsp_status),
      .rsp_result_index      (rsp_result_index),
      .rsp_result_generation (rsp_result_generation)
   );

`ifndef NO_ASSERTIONS
   // an accepted transaction always occupies the unit next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // a response only follows a cycle in which a transaction was in work
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a transaction in work");

   // every command passes lookup and execute after it is taken, so strobes never touch
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back response strobes");

   // error responses carry no generation
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != gsa_pkg::STATUS_OK)) |-> (rsp_result_generation == '0))
      else $error("error response with nonzero generation");
`endif

endmodule

// File: tb/sv/slot_allocator_checker.sv
// ---------------------------------------------------------------------------
// slot_allocator_checker: response checker for the slot allocator
// Watches the command, response and CSR channels, keeps a shadow copy of
// the free list, slot generations and LFSR, and compares every response.
// ---------------------------------------------------------------------------
module slot_allocator_checker #(
   parameter int BLOCKS          = 16,
   parameter int SLOTS_PER_BLOCK = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [gsa_pkg::CMD_W-1:0]     req_command,
   input  logic [gsa_pkg::IDX_W-1:0]     req_slot_index,
   input  logic [gsa_pkg::IDX_W-1:0]     req_handle_index,
   input  logic [gsa_pkg::GEN_W-1:0]     req_handle_generation,
   input  logic                          rsp_strobe,
   input  logic [gsa_pkg::STATUS_W-1:0]  rsp_status,
   input  logic [gsa_pkg::IDX_W-1:0]     rsp_result_index,
   input  logic [gsa_pkg::GEN_W-1:0]     rsp_result_generation,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [gsa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gsa_pkg::CSR_DAT_W-1:0] csr_data,
   output int                            mismatches,
   output int                            outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import gsa_pkg::*;

   localparam int TOTAL_SLOTS = BLOCKS * SLOTS_PER_BLOCK;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    index;
      logic [GEN_W-1:0]    generation;
   } slot_result_type;

   // shadow allocator state
   int unsigned          link_mem [TOTAL_SLOTS];
   logic [GEN_W-1:0]     gen_mem  [TOTAL_SLOTS];
   int unsigned          head;
   int unsigned          tail;
   bit                   list_empty;
   int unsigned          blocks_on;
   logic [GEN_W-1:0]     lfsr;
   logic [ALLOWED_W-1:0] allowed;

   slot_result_type owed_results[$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   function automatic logic [GEN_W-1:0] advance_lfsr(input logic [GEN_W-1:0] v);
      return v[0] ? ({1'b0, v[GEN_W-1:1]} ^ LFSR_TAPS) : {1'b0, v[GEN_W-1:1]};
   endfunction

   function automatic int unsigned block_cap();
      return (32'(allowed) < 32'(BLOCKS)) ? 32'(allowed) : 32'(BLOCKS);
   endfunction

   function automatic bit slot_on(input logic [IDX_W-1:0] s);
      return (32'(s) < blocks_on * 32'(SLOTS_PER_BLOCK)) && (32'(s) < 32'(TOTAL_SLOTS));
   endfunction

   task automatic owe_result(input logic [STATUS_W-1:0] st, input logic [IDX_W-1:0] idx,
                             input logic [GEN_W-1:0] gen);
      slot_result_type r;
      r.status     = st;
      r.index      = idx;
      r.generation = gen;
      owed_results.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input logic [GEN_W-1:0] got,
                                  input logic [GEN_W-1:0] want);
      $display("%0t: slot allocator %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DAT_W-1:0] data);
      if (idx == CSR_SEED) begin
         lfsr = data;   // seed write also reloads the LFSR
      end else if (idx == CSR_ALLOWED) begin
         allowed = data[ALLOWED_W-1:0];
      end
   endtask

   task automatic predict_command(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] sidx,
                                  input logic [IDX_W-1:0] hidx, input logic [GEN_W-1:0] hgen);
      int unsigned s;
      int unsigned base;
      int unsigned j;
      logic [GEN_W-1:0] g;
      if (cmd == CMD_ALLOC) begin
         if (list_empty && blocks_on >= block_cap()) begin
            owe_result(STATUS_FULL, '0, '0);
         end else begin
            if (list_empty) begin
               // bring up the next block, slots linked in ascending order
               base = blocks_on * SLOTS_PER_BLOCK;
               for (j = 0; j < SLOTS_PER_BLOCK; j++) begin
                  lfsr = advance_lfsr(lfsr);
                  gen_mem[base + j]  = (lfsr == '0) ? GEN_W'(1) : lfsr;
                  link_mem[base + j] = base + j + 1;
               end
               head       = base;
               tail       = base + SLOTS_PER_BLOCK - 1;
               list_empty = 1'b0;
               blocks_on++;
            end
            s = head;
            g = gen_mem[s];
            if (s == tail) begin
               list_empty = 1'b1;
            end else begin
               head = (link_mem[s] < TOTAL_SLOTS) ? link_mem[s] : 0;
            end
            owe_result(STATUS_OK, IDX_W'(s), g);
         end
      end else if (cmd == CMD_FREE) begin
         if (!slot_on(sidx)) begin
            owe_result(STATUS_DISABLED, sidx, '0);
         end else begin
            g = gen_mem[sidx] + GEN_W'(1);
            if (g == '0) begin
               g = GEN_W'(1);
            end
            gen_mem[sidx] = g;
            if (list_empty) begin
               tail           = 32'(sidx);
               link_mem[sidx] = 32'(sidx);
            end else begin
               link_mem[sidx] = head;
            end
            head       = 32'(sidx);
            list_empty = 1'b0;
            owe_result(STATUS_OK, sidx, g);
         end
      end else if (cmd == CMD_LOOKUP) begin
         if (!slot_on(hidx)) begin
            owe_result(STATUS_DISABLED, hidx, '0);
         end else if (gen_mem[hidx] != hgen) begin
            owe_result(STATUS_STALE, hidx, '0);
         end else begin
            owe_result(STATUS_OK, hidx, gen_mem[hidx]);
         end
      end else if (cmd == CMD_REVERSE) begin
         if (!slot_on(sidx)) begin
            owe_result(STATUS_DISABLED, sidx, '0);
         end else begin
            owe_result(STATUS_OK, sidx, gen_mem[sidx]);
         end
      end else if (cmd == CMD_CLEAR) begin
         // LFSR keeps running across a clear
         blocks_on  = 0;
         head       = 0;
         tail       = 0;
         list_empty = 1'b1;
         owe_result(STATUS_OK, '0, '0);
      end
   endtask

   task automatic check_result();
      slot_result_type want;
      if (owed_results.size() == 0) begin
         report_mismatch("response with no transaction outstanding",
                         GEN_W'(rsp_result_index), '0);
      end else begin
         want = owed_results.pop_front();
         if (rsp_status !== want.status) begin
            report_mismatch("status", GEN_W'(rsp_status), GEN_W'(want.status));
         end
         if (rsp_result_index !== want.index) begin
            report_mismatch("result_index", GEN_W'(rsp_result_index), GEN_W'(want.index));
         end
         if (rsp_result_generation !== want.generation) begin
            report_mismatch("result_generation", rsp_result_generation, want.generation);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         head       = 0;
         tail       = 0;
         list_empty = 1'b1;
         blocks_on  = 0;
         lfsr       = SEED_RESET;
         allowed    = ALLOWED_RESET;
         owed_results.delete();
      end else begin
         // retire first: a response never belongs to a same-edge transaction
         if (rsp_strobe) begin
            check_result();
         end
         if (csr_valid && csr_ready) begin
            write_register(csr_index, csr_data);
         end
         if (start && !busy) begin
            predict_command(req_command, req_slot_index, req_handle_index,
                            req_handle_generation);
         end
      end
      outstanding = owed_results.size();
   end

endmodule

// File: tb/sv/generational_slot_allocator_unit_tb.sv
// ---------------------------------------------------------------------------
// generational_slot_allocator_unit_tb: testbench of the slot allocator
// Directed corner cases then handle-driven random traffic over several
// seed/block-limit settings; a side checker predicts and compares.
// ---------------------------------------------------------------------------
module generational_slot_allocator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gsa_pkg::*;

   localparam int BLOCKS          = 16;
   localparam int SLOTS_PER_BLOCK = 64;
   localparam int SEGMENTS        = 4;
   localparam int SEGMENT_ITEMS   = 350;
   localparam int SETTLE_CYCLES   = 8;     // dropped commands finish well within this
   localparam int TAIL_CYCLES     = 20;
   localparam int WATCHDOG_LIMIT  = 4000;  // idle cycles

   // codes 5..7 are not commands; the unit drops them silently
   localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;

   // seed whose first LFSR step is all ones, so a free wraps the generation
   localparam logic [GEN_W-1:0] SEED_ALL_ONES_NEXT = 32'hFFBF_FFF9;

   typedef struct {
      logic [IDX_W-1:0] index;
      logic [GEN_W-1:0] generation;
   } handle_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [CMD_W-1:0]     req_command = '0;
   logic [IDX_W-1:0]     req_slot_index = '0;
   logic [IDX_W-1:0]     req_handle_index = '0;
   logic [GEN_W-1:0]     req_handle_generation = '0;
   logic                 rsp_strobe;
   logic [STATUS_W-1:0]  rsp_status;
   logic [IDX_W-1:0]     rsp_result_index;
   logic [GEN_W-1:0]     rsp_result_generation;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   int chk_mismatches;
   int chk_outstanding;

   // stimulus bookkeeping: which known commands are in flight, and which
   // handles the unit has handed out (live) or that we since freed (retired)
   logic [CMD_W-1:0] inflight_cmds[$];
   handle_type       live_handles[$];
   handle_type       retired_handles[$];
   logic [CMD_W-1:0] answered_cmd;
   handle_type       seen_handle;

   int idle_pct;
   int items;
   int burst_items;
   int seg;
   int watchdog = 0;

   logic [GEN_W-1:0]     seg_seed    [SEGMENTS];
   logic [ALLOWED_W-1:0] seg_allowed [SEGMENTS];
   bit                   seg_clear   [SEGMENTS];
   int                   seg_idle    [SEGMENTS];

   generational_slot_allocator_unit #(
      .BLOCKS          (BLOCKS),
      .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK)
   ) uut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_command           (req_command),
      .req_slot_index        (req_slot_index),
      .req_handle_index      (req_handle_index),
      .req_handle_generation (req_handle_generation),
      .rsp_strobe            (rsp_strobe),
      .rsp_status            (rsp_status),
      .rsp_result_index      (rsp_result_index),
      .rsp_result_generation (rsp_result_generation),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   slot_allocator_checker #(
      .BLOCKS          (BLOCKS),
      .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK)
   ) u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_command           (req_command),
      .req_slot_index        (req_slot_index),
      .req_handle_index      (req_handle_index),
      .req_handle_generation (req_handle_generation),
      .rsp_strobe            (rsp_strobe),
      .rsp_status            (rsp_status),
      .rsp_result_index      (rsp_result_index),
      .rsp_result_generation (rsp_result_generation),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .mismatches            (chk_mismatches),
      .outstanding           (chk_outstanding)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Harvest handles from responses so later frees and lookups are
   // well formed. Responses come back in command order.
   always @(posedge clock) begin
      if (!reset && rsp_strobe && inflight_cmds.size() != 0) begin
         answered_cmd = inflight_cmds.pop_front();
         if (answered_cmd == CMD_ALLOC && rsp_status == STATUS_OK) begin
            seen_handle.index      = rsp_result_index;
            seen_handle.generation = rsp_result_generation;
            live_handles.push_back(seen_handle);
         end else if (answered_cmd == CMD_CLEAR) begin
            live_handles.delete();
         end
      end
   end

   // Watchdog: cycles with no transaction on any channel.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         watchdog <= 0;
      end else if (watchdog >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         watchdog <= watchdog + 1;
      end
   end

   // Drive one command transaction: random idle gaps, then hold start
   // until the unit takes it (start high, busy low at the edge).
   task automatic issue(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] sidx,
                        input logic [IDX_W-1:0] hidx, input logic [GEN_W-1:0] hgen);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start                 = 1'b1;
      req_command           = cmd;
      req_slot_index        = sidx;
      req_handle_index      = hidx;
      req_handle_generation = hgen;
      do begin
         @(posedge clock);
      end while (busy);
      if (cmd <= CMD_CLEAR) begin
         inflight_cmds.push_back(cmd);
      end
   endtask

   // Sender backs off until every outstanding response has come back.
   task automatic wait_responses();
      @(negedge clock);
      start = 1'b0;
      while (chk_outstanding != 0) begin
         @(negedge clock);
      end
   endtask

   // Quiesce before a register write: a dropped command may still be in
   // the pipe with nothing outstanding, so wait out SETTLE_CYCLES and busy too.
   task automatic wait_idle();
      wait_responses();
      repeat (SETTLE_CYCLES) @(negedge clock);
      while (busy) begin
         @(negedge clock);
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic handle_type pick_handle(input bit from_live);
      if (from_live) begin
         return live_handles[$urandom_range(live_handles.size() - 1)];
      end
      return retired_handles[$urandom_range(retired_handles.size() - 1)];
   endfunction

   // One random step; returns how many command transactions it counted.
   // Mostly well-formed: frees and lookups use handles the unit gave out.
   task automatic random_step(output int counted);
      int unsigned      pick;
      int unsigned      k;
      int               n;
      handle_type       h;
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] sidx;
      logic [IDX_W-1:0] hidx;
      logic [GEN_W-1:0] hgen;
      pick    = $urandom_range(99);
      sidx    = IDX_W'($urandom_range(2**IDX_W - 1));
      hidx    = IDX_W'($urandom_range(2**IDX_W - 1));
      hgen    = $urandom();
      counted = 1;
      if (pick < 2) begin
         // allocation burst: pushes the pool into new blocks and to full
         n = $urandom_range(20, 70);
         repeat (n) issue(CMD_ALLOC, IDX_W'($urandom_range(2**IDX_W - 1)),
                          IDX_W'($urandom_range(2**IDX_W - 1)), $urandom());
         counted = n;
      end else if (pick < 36) begin
         issue(CMD_ALLOC, sidx, hidx, hgen);
      end else if (pick < 56) begin
         if (live_handles.size() != 0 && $urandom_range(9) < 8) begin
            k = $urandom_range(live_handles.size() - 1);
            h = live_handles[k];
            live_handles.delete(k);
            retired_handles.push_back(h);
            if (retired_handles.size() > 64) begin
               void'(retired_handles.pop_front());
            end
            sidx = h.index;
         end
         issue(CMD_FREE, sidx, hidx, hgen);
      end else if (pick < 78) begin
         k = $urandom_range(9);
         if (k < 6 && live_handles.size() != 0) begin
            h    = pick_handle(1'b1);
            hidx = h.index;
            hgen = h.generation;
         end else if (k < 8 && retired_handles.size() != 0) begin
            h    = pick_handle(1'b0);
            hidx = h.index;
            hgen = h.generation;
         end
         if ($urandom_range(5) == 0) begin
            case ($urandom_range(2))
               0: begin
                  hgen = hgen ^ (GEN_W'(1) << $urandom_range(GEN_W - 1));
               end
               1: begin
                  hgen = '0;
               end
               default: begin
                  hgen = '1;
               end
            endcase
         end
         issue(CMD_LOOKUP, sidx, hidx, hgen);
      end else if (pick < 96) begin
         if (live_handles.size() != 0 && $urandom_range(3) != 0) begin
            h    = pick_handle(1'b1);
            sidx = h.index;
         end
         issue(CMD_REVERSE, sidx, hidx, hgen);
      end else if (pick < 97) begin
         issue(CMD_CLEAR, sidx, hidx, hgen);
      end else begin
         cmd = CMD_UNKNOWN_LO + CMD_W'($urandom_range(2));
         issue(cmd, sidx, hidx, hgen);
         counted = 0;   // dropped, not a real item
      end
   endtask

   initial begin
      idle_pct = 6;

      // segment plan: seed, block limit, start with clear, sender idling
      seg_seed[0] = $urandom();  seg_allowed[0] = 5'd16; seg_clear[0] = 1'b1; seg_idle[0] = 6;
      seg_seed[1] = '1;          seg_allowed[1] = 5'd2;  seg_clear[1] = 1'b1; seg_idle[1] = 80;
      seg_seed[2] = $urandom();  seg_allowed[2] = 5'd31; seg_clear[2] = 1'b0; seg_idle[2] = 0;
      seg_seed[3] = $urandom();  seg_allowed[3] = 5'd1;  seg_clear[3] = 1'b0; seg_idle[3] = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed ---
      // nothing enabled yet: every slot reads as disabled
      issue(CMD_LOOKUP, '0, '1, '1);
      issue(CMD_REVERSE, '0, '1, '0);
      issue(CMD_FREE, '1, '0, '0);

      // a limit of zero blocks makes the very first allocate report full
      wait_idle();
      write_csr(CSR_ALLOWED, '0);
      issue(CMD_ALLOC, '0, '0, '0);

      // first generation of block 0 comes out all ones
      wait_idle();
      write_csr(CSR_SEED, SEED_ALL_ONES_NEXT);
      write_csr(CSR_ALLOWED, 32'd31);
      issue(CMD_ALLOC, '1, '1, '1);
      issue(CMD_ALLOC, '0, '0, '0);
      wait_responses();

      issue(CMD_LOOKUP, '0, '0, '1);                    // exact match
      issue(CMD_LOOKUP, '0, '0, '0);                    // stale, zero generation
      issue(CMD_LOOKUP, '0, '0, 32'hFFFF_FFFE);         // stale, one bit off
      if (live_handles.size() > 1) begin
         issue(CMD_LOOKUP, '0, live_handles[1].index, live_handles[1].generation);
      end
      issue(CMD_REVERSE, 10'd1, '0, '0);
      issue(CMD_REVERSE, 10'(SLOTS_PER_BLOCK - 1), '0, '0);  // enabled, still on list
      issue(CMD_REVERSE, 10'(SLOTS_PER_BLOCK), '0, '0);      // next block, disabled

      // free of slot 0 wraps its generation past zero; slot 1 is freed twice
      issue(CMD_FREE, '0, '0, '0);
      issue(CMD_FREE, 10'd1, '0, '0);
      issue(CMD_FREE, 10'd1, '0, '0);
      repeat (3) issue(CMD_ALLOC, '0, '0, '0);
      issue(CMD_LOOKUP, '0, '0, 32'd1);

      // codes that are not commands get no response
      issue(CMD_UNKNOWN_LO, '1, '1, '1);
      issue(CMD_UNKNOWN_LO + 3'd1, '0, '0, '0);
      issue(CMD_UNKNOWN_LO + 3'd2, '1, '0, '1);

      issue(CMD_CLEAR, '1, '1, '1);
      issue(CMD_REVERSE, '0, '0, '0);

      // zero seed pins the LFSR: every fresh generation is one
      wait_idle();
      write_csr(CSR_SEED, '0);
      issue(CMD_ALLOC, '0, '0, '0);
      issue(CMD_ALLOC, '0, '0, '0);

      // --- random segments ---
      for (seg = 0; seg < SEGMENTS; seg++) begin
         wait_idle();
         write_csr(CSR_SEED, seg_seed[seg]);
         write_csr(CSR_ALLOWED, 32'(seg_allowed[seg]));
         idle_pct = seg_idle[seg];
         items    = 0;
         if (seg_clear[seg]) begin
            issue(CMD_CLEAR, '0, '0, '0);
            items++;
         end
         while (items < SEGMENT_ITEMS) begin
            random_step(burst_items);
            items += burst_items;
            if ($urandom_range(199) == 0) begin
               wait_responses();
            end
         end
      end

      // drain, then let any late or spurious response show up
      wait_responses();
      repeat (TAIL_CYCLES) @(negedge clock);

      if (chk_mismatches == 0 && chk_outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: generational_slot_allocator_unit.f
rtl/gsa_pkg.sv
rtl/gsa_ctrl.sv
rtl/gsa_datapath.sv
rtl/generational_slot_allocator_unit.sv
tb/sv/slot_allocator_checker.sv
tb/sv/generational_slot_allocator_unit_tb.sv
